FILE: hdl/pdtq_pkg.sv
// ----------------------------------------------------------------------------
// pdtq_pkg
// Shared types and codes for the periodic deadline task queue.
// ----------------------------------------------------------------------------
package pdtq_pkg;

  localparam int OP_W     = 3;
  localparam int TICK_W   = 32;
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int QCNT_W   = 5;
  localparam int ID_SLOTS = 16;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_INIT   = 3'd1,
    OP_HEAD   = 3'd2,
    OP_SYS    = 3'd3,
    OP_PERIOD = 3'd4
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  // Per-cycle command broadcast to every list cell.
  typedef struct packed {
    logic ins;      // insert transfer this cycle
    logic pop;      // remove head this cycle
    logic at_head;  // insert position forced to the front
    logic upd_due;  // the op rewrites the task's due tick
  } ctrl_t;

endpackage

FILE: hdl/pdtq_if.sv
// ----------------------------------------------------------------------------
// pdtq_if
// Valid/ready channels: task commands in, scheduling results out.
// ----------------------------------------------------------------------------
interface pdtq_in_if;
  logic                           valid;
  logic                           ready;
  logic [pdtq_pkg::OP_W-1:0]      op;
  logic [pdtq_pkg::TICK_W-1:0]    now_tick;
  logic [pdtq_pkg::ID_W-1:0]      task_id;
  logic [pdtq_pkg::TICK_W-1:0]    period;
  logic [pdtq_pkg::PRIO_W-1:0]    prio;

  modport source (output valid, output op, output now_tick, output task_id,
                  output period, output prio, input ready);
  modport sink   (input valid, input op, input now_tick, input task_id,
                  input period, input prio, output ready);
endinterface

interface pdtq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [pdtq_pkg::ID_W-1:0]      granted_id;
  logic [pdtq_pkg::STATUS_W-1:0]  status;
  logic [pdtq_pkg::QCNT_W-1:0]    queued_count;

  modport source (output valid, output granted, output granted_id,
                  output status, output queued_count, input ready);
  modport sink   (input valid, input granted, input granted_id,
                  input status, input queued_count, output ready);
endinterface

FILE: hdl/pdtq_cell.sv
// ----------------------------------------------------------------------------
// pdtq_cell
// One slot of the sorted ready list: compares against the insert key,
// shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module pdtq_cell #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 5,
  parameter int TICK_BITS = 32
) (
  input  logic                          clk,
  input  pdtq_pkg::ctrl_t               ctrl,
  input  logic [CNT_W-1:0]              cnt,
  input  logic [TICK_BITS-1:0]          key,
  input  logic [pdtq_pkg::ID_W-1:0]     new_id,
  input  logic [TICK_BITS-1:0]          new_due,
  input  logic [pdtq_pkg::PRIO_W-1:0]   new_prio,
  // from the left neighbor (insert shift)
  input  logic                          hit_in,
  input  logic [pdtq_pkg::ID_W-1:0]     left_id,
  input  logic [TICK_BITS-1:0]          left_due,
  input  logic [pdtq_pkg::PRIO_W-1:0]   left_prio,
  // from the right neighbor (pop shift)
  input  logic [pdtq_pkg::ID_W-1:0]     right_id,
  input  logic [TICK_BITS-1:0]          right_due,
  input  logic [pdtq_pkg::PRIO_W-1:0]   right_prio,
  output logic                          hit_out,
  output logic [pdtq_pkg::ID_W-1:0]     id,
  output logic [TICK_BITS-1:0]          due,
  output logic [pdtq_pkg::PRIO_W-1:0]   prio,
  output logic [TICK_BITS-1:0]          eff_due,
  output logic [pdtq_pkg::PRIO_W-1:0]   eff_prio
);

  logic occ;
  logic same;
  logic later;
  logic mark;

  // Entries sharing the inserted id see the table update first.
  assign occ      = CNT_W'(IDX) < cnt;
  assign same     = (id == new_id);
  assign eff_prio = (ctrl.ins && same) ? new_prio : prio;
  assign eff_due  = (ctrl.ins && ctrl.upd_due && same) ? new_due : due;
  assign later    = (eff_due > key) || ((eff_due == key) && (eff_prio > new_prio));
  assign mark     = ctrl.at_head || !occ || later;
  assign hit_out  = hit_in || mark;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit_in) begin
        id   <= left_id;
        due  <= left_due;
        prio <= left_prio;
      end else if (mark) begin
        id   <= new_id;
        due  <= new_due;
        prio <= new_prio;
      end else begin
        due  <= eff_due;
        prio <= eff_prio;
      end
    end else if (ctrl.pop) begin
      id   <= right_id;
      due  <= right_due;
      prio <= right_prio;
    end
  end

endmodule

FILE: hdl/periodic_deadline_task_queue_top.sv
// ----------------------------------------------------------------------------
// periodic_deadline_task_queue_top
// Ready list of tasks kept in due-tick order, as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : valid/ready command channel (op, now_tick, task_id, period, prio).
//   res : valid/ready result channel, one result per command transfer
//         (granted, granted_id, status, queued_count).
// Timing:
//   A command transfer is taken in the idle state; in the apply state that
//   follows, every cell compares its entry against the insert key in parallel,
//   the insert point ripples down the cell row and all cells shift at once,
//   and the result register is loaded at the same edge. A new command is
//   not taken until the apply state has finished.
// Stalls:
//   The result register holds while res.ready is low; the next command can
//   still be taken, and its shift cycle waits until the register frees up.
// Reset:
//   rst empties the list (fill count to zero), returns the control to idle
//   and drops the result valid. Cell contents and the due-tick table are not
//   cleared; slots above the fill count are ignored.
// Full list: an insert is refused with status full and nothing changes.
// ----------------------------------------------------------------------------
module periodic_deadline_task_queue_top #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  pdtq_in_if.sink           cmd,
  pdtq_out_if.source        res
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  pdtq_pkg::state_t state, state_next;

  // latched command
  logic [pdtq_pkg::OP_W-1:0]   op;
  logic [pdtq_pkg::ID_W-1:0]   task_id;
  logic [pdtq_pkg::PRIO_W-1:0] prio;
  logic [TICK_BITS-1:0]        now_tick;
  logic [TICK_BITS-1:0]        key;
  logic [TICK_BITS-1:0]        new_due;

  logic [CNT_W-1:0]            cnt, cnt_next;
  logic [TICK_BITS-1:0]        due_tab [pdtq_pkg::ID_SLOTS];

  // accept-side helpers
  logic                        take;
  logic [TICK_BITS-1:0]        now_in;
  logic [TICK_BITS-1:0]        period_in;
  logic [TICK_BITS-1:0]        due_old;
  logic [TICK_BITS-1:0]        due_sum;

  // apply-side helpers
  logic                        go;
  logic                        is_get;
  logic                        is_ins;
  logic                        full;
  logic                        empty;
  logic                        pop;
  logic                        ins;
  pdtq_pkg::ctrl_t             ctrl;

  // cell row
  logic [pdtq_pkg::ID_W-1:0]   c_id   [MAX_TASKS];
  logic [TICK_BITS-1:0]        c_due  [MAX_TASKS];
  logic [pdtq_pkg::PRIO_W-1:0] c_prio [MAX_TASKS];
  logic [TICK_BITS-1:0]        e_due  [MAX_TASKS];
  logic [pdtq_pkg::PRIO_W-1:0] e_prio [MAX_TASKS];
  logic [MAX_TASKS:0]          hit;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdtq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pdtq_pkg::S_IDLE: begin
        if (cmd.valid) state_next = pdtq_pkg::S_APPLY;
      end
      pdtq_pkg::S_APPLY: begin
        if (!res.valid || res.ready) state_next = pdtq_pkg::S_IDLE;
      end
      default: state_next = pdtq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    go        = 1'b0;
    case (state)
      pdtq_pkg::S_IDLE:  cmd.ready = 1'b1;
      pdtq_pkg::S_APPLY: go = !res.valid || res.ready;
      default: begin
        cmd.ready = 1'b0;
        go        = 1'b0;
      end
    endcase
  end

  // ----------------------------------------------------------- accept cycle
  assign take      = cmd.valid && cmd.ready;
  assign now_in    = TICK_BITS'(cmd.now_tick);
  assign period_in = TICK_BITS'(cmd.period);
  assign due_old   = due_tab[cmd.task_id];
  assign due_sum   = due_old + period_in;   // wraps at TICK_BITS

  always_ff @(posedge clk) begin
    if (take) begin
      op       <= cmd.op;
      task_id  <= cmd.task_id;
      prio     <= cmd.prio;
      now_tick <= now_in;
      // period reschedule sorts on the new due tick, others on now
      key      <= (cmd.op == pdtq_pkg::OP_PERIOD) ? due_sum : now_in;
      // due tick the inserted entry carries; system reschedule and head
      // requeue keep the old one
      if (cmd.op == pdtq_pkg::OP_INIT) begin
        new_due <= now_in;
      end else if (cmd.op == pdtq_pkg::OP_PERIOD) begin
        new_due <= due_sum;
      end else begin
        new_due <= due_old;
      end
    end
  end

  // ------------------------------------------------------------ apply cycle
  assign is_get = (op == pdtq_pkg::OP_GET);
  assign is_ins = (op == pdtq_pkg::OP_INIT) || (op == pdtq_pkg::OP_HEAD) ||
                  (op == pdtq_pkg::OP_SYS)  || (op == pdtq_pkg::OP_PERIOD);
  assign full   = (cnt == CNT_W'(MAX_TASKS));
  assign empty  = (cnt == '0);
  // head is due when now has reached its due tick (plain unsigned compare)
  assign pop    = go && is_get && !empty && (now_tick >= c_due[0]);
  assign ins    = go && is_ins && !full;

  assign ctrl.ins     = ins;
  assign ctrl.pop     = pop;
  assign ctrl.at_head = (op == pdtq_pkg::OP_HEAD);
  assign ctrl.upd_due = (op == pdtq_pkg::OP_INIT) || (op == pdtq_pkg::OP_PERIOD);

  always_comb begin
    cnt_next = cnt;
    if (ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (pop) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ins && ctrl.upd_due) begin
      due_tab[task_id] <= new_due;
    end
  end

  // --------------------------------------------------------------- cell row
  assign hit[0] = 1'b0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    logic [pdtq_pkg::ID_W-1:0]   l_id,   r_id;
    logic [TICK_BITS-1:0]        l_due,  r_due;
    logic [pdtq_pkg::PRIO_W-1:0] l_prio, r_prio;

    if (g == 0) begin : g_first
      assign l_id   = task_id;
      assign l_due  = new_due;
      assign l_prio = prio;
    end else begin : g_mid
      assign l_id   = c_id[g-1];
      assign l_due  = e_due[g-1];
      assign l_prio = e_prio[g-1];
    end

    // last slot pulls in nothing useful on pop; it falls above the count
    if (g == MAX_TASKS - 1) begin : g_last
      assign r_id   = c_id[g];
      assign r_due  = c_due[g];
      assign r_prio = c_prio[g];
    end else begin : g_body
      assign r_id   = c_id[g+1];
      assign r_due  = c_due[g+1];
      assign r_prio = c_prio[g+1];
    end

    pdtq_cell #(
      .IDX       (g),
      .CNT_W     (CNT_W),
      .TICK_BITS (TICK_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cnt        (cnt),
      .key        (key),
      .new_id     (task_id),
      .new_due    (new_due),
      .new_prio   (prio),
      .hit_in     (hit[g]),
      .left_id    (l_id),
      .left_due   (l_due),
      .left_prio  (l_prio),
      .right_id   (r_id),
      .right_due  (r_due),
      .right_prio (r_prio),
      .hit_out    (hit[g+1]),
      .id         (c_id[g]),
      .due        (c_due[g]),
      .prio       (c_prio[g]),
      .eff_due    (e_due[g]),
      .eff_prio   (e_prio[g])
    );
  end

  // ---------------------------------------------------------- result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (go) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res.granted      <= pop;
      res.granted_id   <= pop ? c_id[0] : '0;
      res.queued_count <= pdtq_pkg::QCNT_W'(cnt_next);
      if (is_get && !pop) begin
        res.status <= pdtq_pkg::ST_NONE;
      end else if (is_ins && full) begin
        res.status <= pdtq_pkg::ST_FULL;
      end else begin
        res.status <= pdtq_pkg::ST_OK;
      end
    end
  end

endmodule

FILE: hdl/pdtq_checker.sv
// ----------------------------------------------------------------------------
// pdtq_checker
// Port-level checks for the task queue, bound to the top level.
// ----------------------------------------------------------------------------
module pdtq_checker #(
  parameter int MAX_TASKS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            out_valid,
  input  logic                            granted,
  input  logic [pdtq_pkg::ID_W-1:0]       granted_id,
  input  logic [pdtq_pkg::STATUS_W-1:0]   status,
  input  logic [pdtq_pkg::QCNT_W-1:0]     queued_count
);

  // one command in flight: no transfer on the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command taken on back-to-back cycles");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (status == pdtq_pkg::ST_OK))
    else $error("grant with non-ok status");

  a_no_grant_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (granted_id == '0))
    else $error("id shown without a grant");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == pdtq_pkg::ST_FULL) |->
      (queued_count == pdtq_pkg::QCNT_W'(MAX_TASKS)))
    else $error("full status with list not full");

endmodule

bind periodic_deadline_task_queue_top pdtq_checker #(
  .MAX_TASKS (MAX_TASKS)
) u_pdtq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (cmd.valid),
  .in_ready     (cmd.ready),
  .out_valid    (res.valid),
  .granted      (res.granted),
  .granted_id   (res.granted_id),
  .status       (res.status),
  .queued_count (res.queued_count)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the periodic deadline task queue. A directed table
// covers reset, the field extremes, every op, the full list and the unused op
// codes. Random blocks of fill, drain and mixed traffic follow; both channels
// idle at random. Every result is checked field by field, against the answer
// a directed row gives or else an in-bench model of the sorted ready list.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // List depth matches the default MAX_TASKS of the block.
  localparam int LIST_DEPTH  = 16;
  localparam int DIR_N       = 26;
  localparam int RAND_CMDS   = 1200;
  localparam int MID_PAUSE   = 600;      // sender waits for an empty pipe here
  localparam int HOLD_AT     = 500;      // receiver holds off after this many
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 800_000;
  localparam int SIDE_CMD    = 0;
  localparam int SIDE_RES    = 1;

  // Op codes the block ignores.
  localparam logic [pdtq_pkg::OP_W-1:0] OP_RSV5 = 3'd5;
  localparam logic [pdtq_pkg::OP_W-1:0] OP_RSV6 = 3'd6;
  localparam logic [pdtq_pkg::OP_W-1:0] OP_RSV7 = 3'd7;

  localparam logic [pdtq_pkg::TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [pdtq_pkg::OP_W-1:0]   op;
    logic [pdtq_pkg::TICK_W-1:0] now_tick;
    logic [pdtq_pkg::ID_W-1:0]   task_id;
    logic [pdtq_pkg::TICK_W-1:0] period;
    logic [pdtq_pkg::PRIO_W-1:0] prio;
  } sched_cmd_t;

  typedef struct packed {
    logic                          granted;
    logic [pdtq_pkg::ID_W-1:0]     granted_id;
    logic [pdtq_pkg::STATUS_W-1:0] status;
    logic [pdtq_pkg::QCNT_W-1:0]   queued_count;
  } sched_res_t;

  // One directed row: the command, and where the answer is obvious, the
  // answer itself. Rows with typed == 0 are checked against the model.
  typedef struct packed {
    sched_cmd_t c;
    logic       typed;
    sched_res_t r;
  } dir_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

  localparam sched_res_t NO_RES = '0;

  dir_row_t dir_rows [DIR_N] = '{
    // empty list after reset
    '{'{pdtq_pkg::OP_GET,    32'd0,    4'd0,  32'd0,    8'd0},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_NONE, 5'd0}},
    // unused codes: no change, plain ok
    '{'{OP_RSV5,             TICK_MAX, 4'd15, TICK_MAX, 8'd255}, 1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd0}},
    '{'{OP_RSV6,             TICK_MAX, 4'd7,  TICK_MAX, 8'd128}, 1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd0}},
    '{'{OP_RSV7,             32'd1,    4'd8,  32'd1,    8'd1},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd0}},
    // init: equal due goes by priority, extremes of the tick
    '{'{pdtq_pkg::OP_INIT,   32'd100,  4'd0,  32'd0,    8'd5},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd1}},
    '{'{pdtq_pkg::OP_INIT,   32'd100,  4'd15, 32'd0,    8'd0},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd2}},
    '{'{pdtq_pkg::OP_INIT,   TICK_MAX, 4'd1,  32'd0,    8'd255}, 1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd3}},
    '{'{pdtq_pkg::OP_INIT,   32'd0,    4'd2,  32'd0,    8'd255}, 1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_OK, 5'd4}},
    // get exactly at due, then get one tick early
    '{'{pdtq_pkg::OP_GET,    32'd0,    4'd0,  32'd0,    8'd0},   1'b1,
      '{1'b1, 4'd2, pdtq_pkg::ST_OK, 5'd3}},
    '{'{pdtq_pkg::OP_GET,    32'd99,   4'd0,  32'd0,    8'd0},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_NONE, 5'd3}},
    // period add that wraps, system reschedule, requeue of a queued task
    '{'{pdtq_pkg::OP_PERIOD, 32'd0,    4'd0,  TICK_MAX, 8'd7},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_SYS,    32'd50,   4'd1,  32'd0,    8'd3},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_HEAD,   32'd0,    4'd15, 32'd0,    8'd0},   1'b0, NO_RES},
    // fill the list
    '{'{pdtq_pkg::OP_INIT,   32'd100,  4'd3,  32'd0,    8'd5},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd100,  4'd4,  32'd0,    8'd6},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd99,   4'd5,  32'd0,    8'd7},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd101,  4'd6,  32'd0,    8'd0},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd50,   4'd7,  32'd0,    8'd3},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd50,   4'd8,  32'd0,    8'd255}, 1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd7,    4'd9,  32'd0,    8'd128}, 1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'd1000, 4'd10, 32'd0,    8'd1},   1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'h8000_0000, 4'd11, 32'd0, 8'd2}, 1'b0, NO_RES},
    '{'{pdtq_pkg::OP_INIT,   32'hFFFF_FFFE, 4'd12, 32'd0, 8'd254}, 1'b0, NO_RES},
    // list full: inserts refused
    '{'{pdtq_pkg::OP_INIT,   32'd200,  4'd13, 32'd0,    8'd1},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_FULL, 5'd16}},
    '{'{pdtq_pkg::OP_PERIOD, 32'd0,    4'd0,  32'd5,    8'd9},   1'b1,
      '{1'b0, 4'd0, pdtq_pkg::ST_FULL, 5'd16}},
    '{'{pdtq_pkg::OP_GET,    TICK_MAX, 4'd0,  32'd0,    8'd0},   1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pdtq_in_if  cmd_ch ();
  pdtq_out_if res_ch ();

  periodic_deadline_task_queue_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the ready list: order of ids, due tick and priority per id.
  // due_known marks ids whose due tick has been written by an init; ops that
  // read a due tick are only issued for those ids.
  // --------------------------------------------------------------------------
  logic [pdtq_pkg::ID_W-1:0]   ready_list [LIST_DEPTH];
  int                          list_len = 0;
  logic [pdtq_pkg::TICK_W-1:0] due_tick   [pdtq_pkg::ID_SLOTS];
  logic [pdtq_pkg::PRIO_W-1:0] task_prio  [pdtq_pkg::ID_SLOTS];
  bit                          due_known  [pdtq_pkg::ID_SLOTS];

  sched_res_t pending_results [$];

  int n_cmds    = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int n_grants  = 0;
  int n_none    = 0;
  int n_full    = 0;
  int cycles    = 0;
  int calm_left [2] = '{0, 0};
  logic [pdtq_pkg::TICK_W-1:0] base_tick = '0;

  // Applies one command to the model list and returns the scheduler answer.
  function automatic sched_res_t run_scheduler(input sched_cmd_t c);
    sched_res_t                  r;
    logic [pdtq_pkg::TICK_W-1:0] key;
    logic [pdtq_pkg::ID_W-1:0]   other;
    logic [pdtq_pkg::ID_W-1:0]   head;
    bit                          ordered;
    int                          pos;
    r = '0;
    case (c.op)
      pdtq_pkg::OP_GET: begin
        if (list_len == 0) begin
          r.status = pdtq_pkg::ST_NONE;
        end else begin
          head = ready_list[0];
          if (c.now_tick >= due_tick[head]) begin
            for (int k = 1; k < list_len; k++) ready_list[k-1] = ready_list[k];
            list_len--;
            r.granted    = 1'b1;
            r.granted_id = head;
          end else begin
            r.status = pdtq_pkg::ST_NONE;
          end
        end
      end
      pdtq_pkg::OP_INIT, pdtq_pkg::OP_HEAD, pdtq_pkg::OP_SYS,
      pdtq_pkg::OP_PERIOD: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = pdtq_pkg::ST_FULL;
        end else begin
          task_prio[c.task_id] = c.prio;
          ordered = 1'b1;
          key     = c.now_tick;
          if (c.op == pdtq_pkg::OP_INIT) begin
            due_tick[c.task_id]  = c.now_tick;
            due_known[c.task_id] = 1'b1;
          end else if (c.op == pdtq_pkg::OP_HEAD) begin
            ordered = 1'b0;
          end else if (c.op == pdtq_pkg::OP_PERIOD) begin
            due_tick[c.task_id] = due_tick[c.task_id] + c.period;
            key = due_tick[c.task_id];
          end
          // system reschedule keys on now but leaves the stored due alone
          pos = 0;
          if (ordered) begin
            while (pos < list_len) begin
              other = ready_list[pos];
              if (due_tick[other] > key ||
                  (due_tick[other] == key && task_prio[other] > c.prio)) break;
              pos++;
            end
          end
          for (int k = list_len; k > pos; k--) ready_list[k] = ready_list[k-1];
          ready_list[pos] = c.task_id;
          list_len++;
        end
      end
      default: ;
    endcase
    r.queued_count = pdtq_pkg::QCNT_W'(list_len);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random command. Fill blocks lean on inserts, drain blocks on gets with
  // late ticks. Ticks mostly track a slowly moving base so gets hit both
  // sides of the head's due tick.
  function automatic sched_cmd_t gen_cmd(input mix_t mix);
    sched_cmd_t c;
    int         r;
    int         get_pct;
    int         start;
    bit         found;
    get_pct   = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 75 : 45;
    c.task_id = pdtq_pkg::ID_W'($urandom_range(0, pdtq_pkg::ID_SLOTS - 1));
    c.period  = ($urandom_range(0, 99) < 6) ? $urandom() : $urandom_range(0, 40);
    c.prio    = pdtq_pkg::PRIO_W'(($urandom_range(0, 99) < 15) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 3) begin
      c.op = OP_RSV5 + pdtq_pkg::OP_W'($urandom_range(0, 2));
    end else if (r < 3 + get_pct) begin
      c.op = pdtq_pkg::OP_GET;
    end else begin
      r = $urandom_range(0, 99);
      c.op = (r < 35) ? pdtq_pkg::OP_INIT : (r < 50) ? pdtq_pkg::OP_HEAD :
             (r < 75) ? pdtq_pkg::OP_SYS  : pdtq_pkg::OP_PERIOD;
    end
    // only ids with a known due tick may enter the list without an init
    if (c.op == pdtq_pkg::OP_HEAD || c.op == pdtq_pkg::OP_SYS ||
        c.op == pdtq_pkg::OP_PERIOD) begin
      found = 1'b0;
      start = int'(c.task_id);
      for (int k = 0; k < pdtq_pkg::ID_SLOTS && !found; k++) begin
        if (due_known[(start + k) % pdtq_pkg::ID_SLOTS]) begin
          c.task_id = pdtq_pkg::ID_W'((start + k) % pdtq_pkg::ID_SLOTS);
          found     = 1'b1;
        end
      end
      if (!found) c.op = pdtq_pkg::OP_INIT;
    end
    base_tick = base_tick + pdtq_pkg::TICK_W'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    if (r < 8)
      c.now_tick = $urandom();
    else if (c.op == pdtq_pkg::OP_GET && mix == MIX_DRAIN && r < 14)
      c.now_tick = TICK_MAX;
    else if (c.op == pdtq_pkg::OP_GET && mix == MIX_DRAIN && r < 45)
      c.now_tick = base_tick + pdtq_pkg::TICK_W'($urandom_range(0, 2000));
    else
      c.now_tick = base_tick + pdtq_pkg::TICK_W'($urandom_range(0, 30));
    return c;
  endfunction

  // Offers one command, waits for its transfer, and records the answer.
  task automatic issue_cmd(input sched_cmd_t c, input bit typed,
                           input sched_res_t typed_res);
    int         gap;
    sched_res_t r;
    gap = pick_gap(SIDE_CMD);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.op       <= c.op;
    cmd_ch.now_tick <= c.now_tick;
    cmd_ch.task_id  <= c.task_id;
    cmd_ch.period   <= c.period;
    cmd_ch.prio     <= c.prio;
    do @(posedge clk); while (!cmd_ch.ready);
    // transfer taken at this edge
    r = run_scheduler(c);
    pending_results.push_back(typed ? typed_res : r);
    if (c.op <= pdtq_pkg::OP_PERIOD) n_cmds++;
  endtask

  // Sender goes quiet until every answer is back.
  task automatic wait_all_answered();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random blocks.
  // --------------------------------------------------------------------------
  initial begin
    mix_t mix;
    int   block_left;
    bit   paused;
    mix             = MIX_BLEND;
    block_left      = 0;
    paused          = 1'b0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.op       <= pdtq_pkg::OP_GET;
    cmd_ch.now_tick <= '0;
    cmd_ch.task_id  <= '0;
    cmd_ch.period   <= '0;
    cmd_ch.prio     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) issue_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
    wait_all_answered();

    while (n_cmds < DIR_N - 3 + RAND_CMDS) begin
      if (block_left == 0) begin
        mix        = mix_t'($urandom_range(0, 2));
        block_left = $urandom_range(10, 60);
        // now and then run close to the top of the tick range
        if ($urandom_range(0, 99) < 8)
          base_tick = TICK_MAX - pdtq_pkg::TICK_W'($urandom_range(0, 300));
      end
      block_left--;
      if (!paused && n_cmds >= MID_PAUSE) begin
        paused = 1'b1;
        wait_all_answered();
      end
      issue_cmd(gen_cmd(mix), 1'b0, NO_RES);
    end

    // let the pipe drain, then a few more cycles for anything stray
    wait_all_answered();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d commands, %0d answers checked: %0d grants, %0d not due or empty,",
             n_cmds, n_checked, n_grants, n_none);
    $display("%0d refused on a full list.", n_full);
    if (n_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, one long hold-off so the block fills and
  // stalls its command side; each transfer is checked against the oldest
  // pending answer.
  // --------------------------------------------------------------------------
  initial begin
    int         gap;
    bit         held;
    sched_res_t exp_r;
    held         = 1'b0;
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && n_checked >= HOLD_AT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = pick_gap(SIDE_RES);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: answer with nothing pending (status %0d, count %0d)",
                 $time, res_ch.status, res_ch.queued_count);
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.granted) n_grants++;
        if (exp_r.status == pdtq_pkg::ST_NONE) n_none++;
        if (exp_r.status == pdtq_pkg::ST_FULL) n_full++;
        check_field("granted",      32'(exp_r.granted),      32'(res_ch.granted));
        check_field("granted_id",   32'(exp_r.granted_id),   32'(res_ch.granted_id));
        check_field("status",       32'(exp_r.status),       32'(res_ch.status));
        check_field("queued_count", 32'(exp_r.queued_count), 32'(res_ch.queued_count));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding",
               cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

FILE: sim.f
hdl/pdtq_pkg.sv
hdl/pdtq_if.sv
hdl/pdtq_cell.sv
hdl/periodic_deadline_task_queue_top.sv
hdl/pdtq_checker.sv
tb/testbench.sv
